// File: sv/vpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpt_pkg
// Shared types, codes and constants of the VirtIO PCI transport register block.
// ----------------------------------------------------------------------------
package vpt_pkg;

    localparam int QUEUE_SLOTS_DEF   = 8;
    localparam int MAX_RING_SIZE_DEF = 256;

    // item kinds
    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_IRQ    = 2'd2,
        CMD_CFGCHG = 2'd3
    } cmd_t;

    localparam logic [15:0] NO_VECTOR = 16'hFFFF;

    // BAR window bases
    localparam logic [13:0] WIN_ISR    = 14'h1000;
    localparam logic [13:0] WIN_DEV    = 14'h2000;
    localparam logic [13:0] WIN_NOTIFY = 14'h3000;

    // common configuration register offsets
    localparam logic [13:0] OFF_DFSEL   = 14'h00;
    localparam logic [13:0] OFF_DF      = 14'h04;
    localparam logic [13:0] OFF_GFSEL   = 14'h08;
    localparam logic [13:0] OFF_GF      = 14'h0C;
    localparam logic [13:0] OFF_MSIX    = 14'h10;
    localparam logic [13:0] OFF_NUMQ    = 14'h12;
    localparam logic [13:0] OFF_STATUS  = 14'h14;
    localparam logic [13:0] OFF_GEN     = 14'h15;
    localparam logic [13:0] OFF_QSEL    = 14'h16;
    localparam logic [13:0] OFF_QSIZE   = 14'h18;
    localparam logic [13:0] OFF_QMSIX   = 14'h1A;
    localparam logic [13:0] OFF_QENABLE = 14'h1C;
    localparam logic [13:0] OFF_QNOFF   = 14'h1E;
    localparam logic [13:0] OFF_QDESC_L = 14'h20;
    localparam logic [13:0] OFF_QDESC_H = 14'h24;
    localparam logic [13:0] OFF_QAVL_L  = 14'h28;
    localparam logic [13:0] OFF_QAVL_H  = 14'h2C;
    localparam logic [13:0] OFF_QUSED_L = 14'h30;
    localparam logic [13:0] OFF_QUSED_H = 14'h34;

    // configuration register indexes
    localparam logic REG_HOST_FEATURES = 1'b0;
    localparam logic REG_QUEUE_COUNT   = 1'b1;

    // one per-queue entry
    typedef struct packed {
        logic [15:0] size;
        logic [15:0] vector;
        logic [15:0] enable;
        logic [63:0] desc;
        logic [63:0] avail;
        logic [63:0] used;
    } queue_entry_t;

    localparam int ENTRY_W = $bits(queue_entry_t);

    // size reset value is filled in by the top level from its parameter
    function automatic queue_entry_t entry_reset(input logic [15:0] ring_size);
        queue_entry_t e;
        e        = '0;
        e.size   = ring_size;
        e.vector = NO_VECTOR;
        return e;
    endfunction

endpackage
`default_nettype wire

// File: sv/virtio_pci_transport_registers.sv
`default_nettype none
// ----------------------------------------------------------------------------
// virtio_pci_transport_registers
// Register side of a modern VirtIO PCI function: common config, ISR, notify.
// ----------------------------------------------------------------------------
// One item per cycle unless a stalled result (m_valid without m_ready)
// holds the stage; results are registered. An accepted item
// issues a read of the per-queue RAM (selected queue, or the interrupting
// queue) and executes in the accepted stage against that entry, writing it back
// when it changes queue state; a write in the previous cycle is forwarded.
// Per-queue entries carry valid flops, so a status-zero reset clears all
// queues at once without any clearing pass.
module virtio_pci_transport_registers
    import vpt_pkg::*;
#(
    parameter int QUEUE_SLOTS   = QUEUE_SLOTS_DEF,
    parameter int MAX_RING_SIZE = MAX_RING_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    // input items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [13:0] s_offset,
    input  wire logic [1:0]  s_access_size,
    input  wire logic [31:0] s_write_data,
    input  wire logic [15:0] s_queue_index,
    input  wire logic        s_suppress_flag,
    // result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_read_data,
    output logic             m_intx_level,
    output logic             m_msi_send,
    output logic      [15:0] m_msi_vector,
    output logic             m_notify_send,
    output logic      [2:0]  m_notify_queue,
    output logic             m_reset_request
);

    localparam int QW  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int LQW = 11;
    localparam logic [LQW-1:0] SLOTS_L = LQW'(QUEUE_SLOTS);
    localparam logic [31:0] MAX_RING = 32'(MAX_RING_SIZE);
    localparam queue_entry_t ENTRY_RST = entry_reset(16'(MAX_RING_SIZE));

    // configuration registers
    logic [63:0] host_features_reg;
    logic [3:0]  queue_count_reg;

    // transport registers
    logic [31:0] dev_fsel_reg, dev_fsel_next;
    logic [31:0] drv_fsel_reg, drv_fsel_next;
    logic [63:0] acc_feat_reg, acc_feat_next;
    logic [15:0] cfg_vec_reg, cfg_vec_next;
    logic [QW-1:0] sel_reg, sel_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  gen_reg, gen_next;
    logic [1:0]  isr_reg, isr_next;
    logic        msix_reg, msix_next;
    logic        intx_reg, intx_next;

    // accepted item stage
    logic        a_valid_reg;
    cmd_t        a_cmd_reg;
    logic [13:0] a_off_reg;
    logic [1:0]  a_size_reg;
    logic [31:0] a_wd_reg;
    logic [15:0] a_qi_reg;
    logic        a_sup_reg;
    logic [QW-1:0] a_addr_reg;

    // per-queue store
    logic [QUEUE_SLOTS-1:0] qvalid_reg;
    logic          byp_valid_reg;
    logic [QW-1:0] byp_addr_reg;
    queue_entry_t  byp_data_reg;
    logic [ENTRY_W-1:0] ram_q;
    logic          ram_we;
    logic [QW-1:0] ram_raddr;
    queue_entry_t  entry, entry_next;

    // output register
    logic        m_valid_reg;
    logic [31:0] m_rd_reg;
    logic        m_intx_reg, m_msi_reg, m_notify_reg, m_rst_reg;
    logic [15:0] m_vec_reg;
    logic [2:0]  m_nq_reg;

    logic        exec, s_acc, do_clear;
    logic [LQW-1:0] live_q;
    logic [31:0] mask, wv, rd_val, rd_common;
    logic        o_msi, o_notify, o_rst;
    logic [15:0] o_vec;
    logic [2:0]  o_nq;
    logic [63:0] feats;
    logic [9:0]  notify_id;
    logic        cfg_wr;

    assign exec    = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !a_valid_reg || exec;
    assign s_acc   = s_valid && s_ready;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    // configuration writes and reads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_features_reg <= '0;
            queue_count_reg   <= 4'd1;
        end else if (cfg_wr) begin
            if (paddr[2:0] == 3'd0) begin
                if (paddr[3] == REG_HOST_FEATURES) begin
                    host_features_reg <= pwdata;
                end else begin
                    queue_count_reg <= pwdata[3:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2:0] == 3'd0) begin
            if (paddr[3] == REG_HOST_FEATURES) begin
                prdata = host_features_reg;
            end else begin
                prdata = {60'd0, queue_count_reg};
            end
        end
    end

    // clamp the queue count to the slot range
    always_comb begin
        if (queue_count_reg == 4'd0) begin
            live_q = LQW'(1);
        end else if (LQW'(queue_count_reg) > SLOTS_L) begin
            live_q = SLOTS_L;
        end else begin
            live_q = LQW'(queue_count_reg);
        end
    end

    // pick the entry: reset value, forwarded write, or RAM data
    always_comb begin
        if (!qvalid_reg[a_addr_reg]) begin
            entry = ENTRY_RST;
        end else if (byp_valid_reg && byp_addr_reg == a_addr_reg) begin
            entry = byp_data_reg;
        end else begin
            entry = queue_entry_t'(ram_q);
        end
    end

    assign feats     = host_features_reg | 64'h0000_0001_0000_0000;
    assign notify_id = a_off_reg[11:2];

    always_comb begin
        case (a_size_reg)
            2'd0:    mask = 32'h0000_00FF;
            2'd1:    mask = 32'h0000_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
    end
    assign wv = a_wd_reg & mask;

    // common configuration read mux
    always_comb begin
        case (a_off_reg)
            OFF_DFSEL: rd_common = dev_fsel_reg;
            OFF_DF: begin
                if (dev_fsel_reg == 32'd0) begin
                    rd_common = feats[31:0];
                end else if (dev_fsel_reg == 32'd1) begin
                    rd_common = feats[63:32];
                end else begin
                    rd_common = '0;
                end
            end
            OFF_GFSEL: rd_common = drv_fsel_reg;
            OFF_GF: begin
                if (drv_fsel_reg == 32'd0) begin
                    rd_common = acc_feat_reg[31:0];
                end else if (drv_fsel_reg == 32'd1) begin
                    rd_common = acc_feat_reg[63:32];
                end else begin
                    rd_common = '0;
                end
            end
            OFF_MSIX:    rd_common = {16'd0, cfg_vec_reg};
            OFF_NUMQ:    rd_common = 32'(live_q);
            OFF_STATUS:  rd_common = {24'd0, status_reg};
            OFF_GEN:     rd_common = {24'd0, gen_reg};
            OFF_QSEL:    rd_common = 32'(sel_reg);
            OFF_QSIZE:   rd_common = {16'd0, entry.size};
            OFF_QMSIX:   rd_common = {16'd0, entry.vector};
            OFF_QENABLE: rd_common = {16'd0, entry.enable};
            OFF_QNOFF:   rd_common = 32'(sel_reg);
            OFF_QDESC_L: rd_common = entry.desc[31:0];
            OFF_QDESC_H: rd_common = entry.desc[63:32];
            OFF_QAVL_L:  rd_common = entry.avail[31:0];
            OFF_QAVL_H:  rd_common = entry.avail[63:32];
            OFF_QUSED_L: rd_common = entry.used[31:0];
            OFF_QUSED_H: rd_common = entry.used[63:32];
            default:     rd_common = '0;
        endcase
    end

    // execute the item in the accepted stage
    always_comb begin
        dev_fsel_next = dev_fsel_reg;
        drv_fsel_next = drv_fsel_reg;
        acc_feat_next = acc_feat_reg;
        cfg_vec_next  = cfg_vec_reg;
        sel_next      = sel_reg;
        status_next   = status_reg;
        gen_next      = gen_reg;
        isr_next      = isr_reg;
        msix_next     = msix_reg;
        intx_next     = intx_reg;
        entry_next    = entry;
        ram_we        = 1'b0;
        do_clear      = 1'b0;
        rd_val        = '0;
        o_msi         = 1'b0;
        o_vec         = '0;
        o_notify      = 1'b0;
        o_nq          = '0;
        o_rst         = 1'b0;
        if (exec) begin
            case (a_cmd_reg)
                CMD_READ: begin
                    if (a_off_reg < WIN_ISR) begin
                        rd_val = rd_common & mask;
                    end else if (a_off_reg < WIN_DEV) begin
                        rd_val   = {30'd0, isr_reg} & mask;
                        isr_next = 2'd0;
                        if (isr_reg != 2'd0) begin
                            intx_next = 1'b0;
                        end
                    end
                end
                CMD_WRITE: begin
                    if (a_off_reg < WIN_ISR) begin
                        case (a_off_reg)
                            OFF_DFSEL: dev_fsel_next = wv;
                            OFF_GFSEL: drv_fsel_next = wv;
                            OFF_GF: begin
                                if (drv_fsel_reg == 32'd0) begin
                                    acc_feat_next[31:0] = wv;
                                end else if (drv_fsel_reg == 32'd1) begin
                                    acc_feat_next[63:32] = wv;
                                end
                            end
                            OFF_MSIX: begin
                                cfg_vec_next = wv[15:0];
                                if (wv[15:0] != NO_VECTOR) begin
                                    msix_next = 1'b1;
                                end
                            end
                            OFF_STATUS: begin
                                if (wv[7:0] == 8'd0) begin
                                    do_clear = 1'b1;
                                    o_rst    = 1'b1;
                                end else begin
                                    status_next = wv[7:0];
                                end
                            end
                            OFF_QSEL: begin
                                if (32'(wv[15:0]) < 32'(live_q)) begin
                                    sel_next = wv[QW-1:0];
                                end
                            end
                            OFF_QSIZE: begin
                                ram_we = 1'b1;
                                if (wv != 32'd0 && wv <= MAX_RING &&
                                    (wv & (wv - 32'd1)) == 32'd0) begin
                                    entry_next.size = wv[15:0];
                                end
                            end
                            OFF_QMSIX: begin
                                ram_we            = 1'b1;
                                entry_next.vector = wv[15:0];
                                if (wv[15:0] != NO_VECTOR) begin
                                    msix_next = 1'b1;
                                end
                            end
                            OFF_QENABLE: begin
                                ram_we            = 1'b1;
                                entry_next.enable = wv[15:0];
                            end
                            OFF_QDESC_L: begin
                                ram_we                = 1'b1;
                                entry_next.desc[31:0] = wv;
                            end
                            OFF_QDESC_H: begin
                                ram_we                 = 1'b1;
                                entry_next.desc[63:32] = wv;
                            end
                            OFF_QAVL_L: begin
                                ram_we                 = 1'b1;
                                entry_next.avail[31:0] = wv;
                            end
                            OFF_QAVL_H: begin
                                ram_we                  = 1'b1;
                                entry_next.avail[63:32] = wv;
                            end
                            OFF_QUSED_L: begin
                                ram_we                = 1'b1;
                                entry_next.used[31:0] = wv;
                            end
                            OFF_QUSED_H: begin
                                ram_we                 = 1'b1;
                                entry_next.used[63:32] = wv;
                            end
                            default: ;
                        endcase
                    end else if (a_off_reg >= WIN_NOTIFY) begin
                        if (LQW'(notify_id) < live_q) begin
                            o_notify = 1'b1;
                            o_nq     = notify_id[2:0];
                        end
                    end
                end
                CMD_IRQ: begin
                    if (LQW'(a_qi_reg) < live_q && a_qi_reg[15:LQW] == '0 &&
                        entry.enable != 16'd0 && !a_sup_reg) begin
                        if (entry.vector != NO_VECTOR) begin
                            o_msi = 1'b1;
                            o_vec = entry.vector;
                        end else if (!msix_reg) begin
                            isr_next  = isr_reg | 2'b01;
                            intx_next = 1'b1;
                        end
                    end
                end
                default: begin
                    gen_next = gen_reg + 8'd1;
                    if (cfg_vec_reg != NO_VECTOR) begin
                        o_msi = 1'b1;
                        o_vec = cfg_vec_reg;
                    end else if (!msix_reg) begin
                        isr_next  = isr_reg | 2'b10;
                        intx_next = 1'b1;
                    end
                end
            endcase
            // status zero: drop all transport state but the generation
            if (do_clear) begin
                dev_fsel_next = '0;
                drv_fsel_next = '0;
                acc_feat_next = '0;
                cfg_vec_next  = NO_VECTOR;
                sel_next      = '0;
                status_next   = '0;
                isr_next      = '0;
                msix_next     = 1'b0;
                intx_next     = 1'b0;
            end
        end
    end

    // RAM read address: the queue the stage item will use next cycle
    always_comb begin
        if (s_acc) begin
            ram_raddr = (cmd_t'(s_cmd) == CMD_IRQ) ? s_queue_index[QW-1:0] : sel_next;
        end else begin
            ram_raddr = (a_cmd_reg == CMD_IRQ) ? a_qi_reg[QW-1:0] : sel_next;
        end
    end

    vpt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_SLOTS)
    ) u_queue_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(a_addr_reg),
        .wdata(entry_next),
        .raddr(ram_raddr),
        .rdata(ram_q)
    );

    // transport state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_fsel_reg  <= '0;
            drv_fsel_reg  <= '0;
            acc_feat_reg  <= '0;
            cfg_vec_reg   <= NO_VECTOR;
            sel_reg       <= '0;
            status_reg    <= '0;
            gen_reg       <= '0;
            isr_reg       <= '0;
            msix_reg      <= 1'b0;
            intx_reg      <= 1'b0;
            qvalid_reg    <= '0;
            byp_valid_reg <= 1'b0;
            a_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            dev_fsel_reg  <= dev_fsel_next;
            drv_fsel_reg  <= drv_fsel_next;
            acc_feat_reg  <= acc_feat_next;
            cfg_vec_reg   <= cfg_vec_next;
            sel_reg       <= sel_next;
            status_reg    <= status_next;
            gen_reg       <= gen_next;
            isr_reg       <= isr_next;
            msix_reg      <= msix_next;
            intx_reg      <= intx_next;
            byp_valid_reg <= ram_we;
            if (do_clear) begin
                qvalid_reg <= '0;
            end else if (ram_we) begin
                qvalid_reg[a_addr_reg] <= 1'b1;
            end
            if (s_acc) begin
                a_valid_reg <= 1'b1;
            end else if (exec) begin
                a_valid_reg <= 1'b0;
            end
            if (exec) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ram_we) begin
            byp_addr_reg <= a_addr_reg;
            byp_data_reg <= entry_next;
        end
        if (s_acc) begin
            a_cmd_reg  <= cmd_t'(s_cmd);
            a_off_reg  <= s_offset;
            a_size_reg <= s_access_size;
            a_wd_reg   <= s_write_data;
            a_qi_reg   <= s_queue_index;
            a_sup_reg  <= s_suppress_flag;
            a_addr_reg <= ram_raddr;
        end
        if (exec) begin
            m_rd_reg     <= rd_val;
            m_intx_reg   <= intx_next;
            m_msi_reg    <= o_msi;
            m_vec_reg    <= o_vec;
            m_notify_reg <= o_notify;
            m_nq_reg     <= o_nq;
            m_rst_reg    <= o_rst;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_read_data     = m_rd_reg;
    assign m_intx_level    = m_intx_reg;
    assign m_msi_send      = m_msi_reg;
    assign m_msi_vector    = m_vec_reg;
    assign m_notify_send   = m_notify_reg;
    assign m_notify_queue  = m_nq_reg;
    assign m_reset_request = m_rst_reg;

    // a reset request always leaves the legacy line low
    a_rst_intx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reset_request |-> !m_intx_level)
        else $error("reset request with INTx high");

    // an MSI-X message never carries the no-vector code
    a_msi_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_msi_send |-> m_msi_vector != NO_VECTOR)
        else $error("MSI-X sent with no vector");

    // a status clear empties the queue store on the next cycle
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        do_clear |=> qvalid_reg == '0 && !intx_reg)
        else $error("queue store not cleared");

    // a queue entry write leaves that entry marked valid
    a_qvalid: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && !do_clear |=> qvalid_reg[$past(a_addr_reg)])
        else $error("queue entry write lost");

endmodule
`default_nettype wire

// File: sv/vpt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
